/* rtl/ils_pkg.sv */
// Shared constants, types and codes for the indexed list store.
`timescale 1ns / 1ps
package ils_pkg;

   localparam int CAPACITY = 64;
   localparam int ELEM_W   = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int REQ_IDX_W = 8;
   localparam int RES_W    = ((LEN_W > REQ_IDX_W) ? LEN_W : REQ_IDX_W) + 1;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 16;

   localparam logic [MODE_W-1:0] MODE_GET    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DEL    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd3;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOB  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [IDX_W-1:0]   pos;
      logic [ELEM_W-1:0]  value;
      logic               rd_load;
      logic               rd_shift;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

/* rtl/ils_cell.sv */
// One storage cell of the list chain: an element word and a read shift stage.
`timescale 1ns / 1ps
module ils_cell (
   input  logic                         clock,
   input  ils_pkg::cell_ctl_type        ctl,
   input  logic [ils_pkg::IDX_W-1:0]    cell_pos,
   input  logic [ils_pkg::ELEM_W-1:0]   prev_elem,
   input  logic [ils_pkg::ELEM_W-1:0]   next_elem,
   input  logic [ils_pkg::ELEM_W-1:0]   next_rd,
   output logic [ils_pkg::ELEM_W-1:0]   elem,
   output logic [ils_pkg::ELEM_W-1:0]   rd
);
   import ils_pkg::*;

   logic [ELEM_W-1:0] elem_ff, elem_in;
   logic [ELEM_W-1:0] rd_ff, rd_in;

   always_comb begin
      elem_in = elem_ff;
      case (ctl.op)
         CELL_WRITE: begin
            if (cell_pos == ctl.pos) elem_in = ctl.value;
         end
         CELL_INSERT: begin
            if (cell_pos == ctl.pos) elem_in = ctl.value;
            else if (cell_pos > ctl.pos) elem_in = prev_elem;
         end
         CELL_DELETE: begin
            if (cell_pos >= ctl.pos) elem_in = next_elem;
         end
         default: elem_in = elem_ff;
      endcase

      rd_in = rd_ff;
      if (ctl.rd_load) rd_in = elem_ff;
      else if (ctl.rd_shift) rd_in = next_rd;
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      rd_ff   <= rd_in;
   end

   assign elem = elem_ff;
   assign rd   = rd_ff;

endmodule

/* rtl/ils_ctrl.sv */
// Request decode, length register, get sequencer and response register.
`timescale 1ns / 1ps
module ils_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ils_pkg::MODE_W-1:0]      req_mode,
   input  logic signed [ils_pkg::REQ_IDX_W-1:0] req_index,
   input  logic [ils_pkg::VALUE_W-1:0]     req_value,
   input  logic [ils_pkg::ELEM_W-1:0]      head_rd,
   output ils_pkg::cell_ctl_type           ctl,
   output logic                            rsp_valid,
   output logic [ils_pkg::VALUE_W-1:0]     rsp_read_value,
   output logic [ils_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ils_pkg::LEN_W-1:0]       rsp_length
);
   import ils_pkg::*;

   state_type            state_ff, state_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   read_value_ff, read_value_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic                 accept;
   logic signed [RES_W-1:0] idx_ext, len_ext, res;
   logic                 in_range, full;
   logic [IDX_W-1:0]     ins_pos;

   always_comb begin
      accept   = start && (state_ff == ST_IDLE);
      idx_ext  = RES_W'(req_index);
      len_ext  = $signed(RES_W'(len_ff));
      res      = (idx_ext < 0) ? (idx_ext + len_ext) : idx_ext;
      in_range = (res >= 0) && (res < len_ext);
      full     = (len_ff == LEN_W'(CAPACITY));
      if (res < 0) ins_pos = '0;
      else if (res > len_ext) ins_pos = len_ff[IDX_W-1:0];
      else ins_pos = res[IDX_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = 1'b0;
      read_value_in = read_value_ff;
      status_in     = status_ff;
      ctl.op        = CELL_HOLD;
      ctl.pos       = res[IDX_W-1:0];
      ctl.value     = ELEM_W'(req_value);
      ctl.rd_load   = 1'b0;
      ctl.rd_shift  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               read_value_in = '0;
               status_in     = STATUS_OK;
               case (req_mode)
                  MODE_GET: begin
                     if (in_range) begin
                        rsp_valid_in = 1'b0;
                        ctl.rd_load  = 1'b1;
                        cnt_in       = res[IDX_W-1:0];
                        state_in     = ST_READ;
                     end else begin
                        status_in = STATUS_OOB;
                     end
                  end
                  MODE_SET: begin
                     if (in_range) ctl.op = CELL_WRITE;
                     else status_in = STATUS_OOB;
                  end
                  MODE_DEL: begin
                     if (in_range) begin
                        ctl.op = CELL_DELETE;
                        len_in = len_ff - LEN_W'(1);
                     end else begin
                        status_in = STATUS_OOB;
                     end
                  end
                  MODE_APPEND: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ctl.op  = CELL_WRITE;
                        ctl.pos = len_ff[IDX_W-1:0];
                        len_in  = len_ff + LEN_W'(1);
                     end
                  end
                  MODE_INSERT: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ctl.op  = CELL_INSERT;
                        ctl.pos = ins_pos;
                        len_in  = len_ff + LEN_W'(1);
                     end
                  end
                  default: status_in = STATUS_OK;
               endcase
            end
         end
         ST_READ: begin
            if (cnt_ff == '0) begin
               rsp_valid_in  = 1'b1;
               read_value_in = VALUE_W'(head_rd);
               status_in     = STATUS_OK;
               state_in      = ST_IDLE;
            end else begin
               ctl.rd_shift = 1'b1;
               cnt_in       = cnt_ff - IDX_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      read_value_ff <= read_value_in;
      status_ff     <= status_in;
   end

   assign busy           = (state_ff == ST_READ);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_length     = len_ff;

   a_no_rsp_while_reading: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("response during get sequence");

   a_get_enters_read: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_GET && in_range) |=> (state_ff == ST_READ))
      else $error("in-range get did not start read sequence");

   a_len_stable_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (len_ff == $past(len_ff)))
      else $error("length changed during get sequence");

   a_single_cycle_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode != MODE_GET) |=> rsp_valid_ff)
      else $error("missing response for one-cycle request");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (len_ff <= LEN_W'(CAPACITY)))
      else $error("length above capacity");

endmodule

/* rtl/indexed_list_store_top.sv */
// Top level of the indexed list store: control plus a chain of storage cells.
`timescale 1ns / 1ps
// Set, delete, append, insert, unknown modes and out-of-range or full requests
// leave busy low, and the response strobes on rsp_valid in the cycle after
// start. A get at resolved index k raises busy while the ST_READ state shifts
// the copied words down the cell chain to cell 0, one cell per cycle; its
// response strobes after the count reaches zero. Responses cannot be stalled.
module indexed_list_store_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ils_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [ils_pkg::REQ_IDX_W-1:0] req_index,
   input  logic [ils_pkg::VALUE_W-1:0]          req_value,
   output logic                                 rsp_valid,
   output logic [ils_pkg::VALUE_W-1:0]          rsp_read_value,
   output logic [ils_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ils_pkg::LEN_W-1:0]            rsp_length
);
   import ils_pkg::*;

   cell_ctl_type      ctl;
   logic [ELEM_W-1:0] elem_w [CAPACITY];
   logic [ELEM_W-1:0] rd_w   [CAPACITY];

   ils_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_index      (req_index),
      .req_value      (req_value),
      .head_rd        (rd_w[0]),
      .ctl            (ctl),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEM_W-1:0] prev_elem, next_elem, next_rd;
      if (i == 0) begin : g_head
         assign prev_elem = ctl.value;
      end else begin : g_mid
         assign prev_elem = elem_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign next_elem = '0;
         assign next_rd   = '0;
      end else begin : g_body
         assign next_elem = elem_w[i+1];
         assign next_rd   = rd_w[i+1];
      end

      ils_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .cell_pos  (IDX_W'(i)),
         .prev_elem (prev_elem),
         .next_elem (next_elem),
         .next_rd   (next_rd),
         .elem      (elem_w[i]),
         .rd        (rd_w[i])
      );
   end

endmodule
